// ===== design/sdag_pkg.sv =====
`timescale 1ns / 1ps

package sdag_pkg;

  localparam int LOCAL_W  = 13;
  localparam int DRAM_W   = 24;
  localparam int DWORD_W  = 23;
  localparam int LEN_W    = 12;
  localparam int ROWS_W   = 8;
  localparam int SKIP_W   = 12;
  localparam int ROWB_W   = 13;

  localparam logic       OP_START = 1'b0;
  localparam logic       OP_STEP  = 1'b1;
  localparam logic [12:0] PAGE_SIZE = 13'h1000;
  localparam logic [12:0] WORD_BYTES = 13'd4;

  // one classified item as it sits in the queue
  typedef struct packed {
    logic                is_start;
    logic [LOCAL_W-1:0]  local_ptr;
    logic [DRAM_W-1:0]   dram_ptr;
    logic [ROWB_W-1:0]   row_bytes;
    logic [ROWS_W-1:0]   rows_left;
    logic [SKIP_W-1:0]   skip_bytes;
    logic                direction;
  } sdag_item_t;

endpackage

// ===== design/sdag_front.sv =====
`timescale 1ns / 1ps

module sdag_front import sdag_pkg::*; (
  input  logic                in_operation,
  input  logic [LOCAL_W-1:0]  in_local_address,
  input  logic [DRAM_W-1:0]   in_dram_address,
  input  logic [LEN_W-1:0]    in_row_length_minus_one,
  input  logic [ROWS_W-1:0]   in_row_count_minus_one,
  input  logic [SKIP_W-1:0]   in_row_skip,
  input  logic                in_to_dram,
  output sdag_item_t          item
);

  logic [LOCAL_W-1:0] lp_aligned;
  logic [ROWB_W-1:0]  len_raw;
  logic [ROWB_W-1:0]  len_round;
  logic [ROWB_W-1:0]  page_off;
  logic [ROWB_W:0]    page_end;

  always_comb begin
    lp_aligned = {in_local_address[LOCAL_W-1:2], 2'b00};
    len_raw    = {1'b0, in_row_length_minus_one} + ROWB_W'(1);
    len_round  = (len_raw + ROWB_W'(7)) & ~ROWB_W'(7);
    page_off   = {1'b0, lp_aligned[11:0]};
    page_end   = {1'b0, page_off} + {1'b0, len_round};

    item.is_start   = (in_operation == OP_START);
    item.local_ptr  = lp_aligned;
    item.dram_ptr   = {in_dram_address[DRAM_W-1:3], 3'b000};
    // first row may not run past the 4 KiB page
    if (page_end > {1'b0, PAGE_SIZE}) begin
      item.row_bytes = PAGE_SIZE - page_off;
    end else begin
      item.row_bytes = len_round;
    end
    item.rows_left  = in_row_count_minus_one;
    item.skip_bytes = in_row_skip;
    item.direction  = in_to_dram;
  end

endmodule

// ===== design/sdag_queue.sv =====
`timescale 1ns / 1ps

module sdag_queue import sdag_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  sdag_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output sdag_item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sdag_item_t         mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/sdag_back.sv =====
`timescale 1ns / 1ps

module sdag_back import sdag_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  sdag_item_t          item,
  output logic                item_take,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_transfer_valid,
  output logic                out_direction_out,
  output logic [DWORD_W-1:0]  out_dram_word_address,
  output logic [LOCAL_W-1:0]  out_local_word_address,
  output logic                out_last_word,
  output logic [LOCAL_W-1:0]  out_local_pointer,
  output logic [DRAM_W-1:0]   out_dram_pointer
);

  logic               busy_r, busy_nxt;
  logic               dir_r, dir_nxt;
  logic [ROWB_W-1:0]  row_bytes_r, row_bytes_nxt;
  logic [SKIP_W-1:0]  skip_r, skip_nxt;
  logic [ROWS_W-1:0]  rows_r, rows_nxt;
  logic [ROWB_W-1:0]  off_r, off_nxt;
  logic [LOCAL_W-1:0] lptr_r, lptr_nxt;
  logic [DRAM_W-1:0]  dptr_r, dptr_nxt;

  logic               ovalid_r;
  logic               tv_r, tv_nxt;
  logic [DWORD_W-1:0] dword_r, dword_nxt;
  logic [LOCAL_W-1:0] lword_r, lword_nxt;
  logic               last_r, last_nxt;

  logic [ROWB_W-1:0]  off_inc;

  assign item_take = item_valid && (!ovalid_r || !out_stall);

  always_comb begin
    busy_nxt      = busy_r;
    dir_nxt       = dir_r;
    row_bytes_nxt = row_bytes_r;
    skip_nxt      = skip_r;
    rows_nxt      = rows_r;
    off_nxt       = off_r;
    lptr_nxt      = lptr_r;
    dptr_nxt      = dptr_r;
    tv_nxt        = 1'b0;
    dword_nxt     = '0;
    lword_nxt     = '0;
    last_nxt      = 1'b0;
    off_inc       = off_r + WORD_BYTES;

    if (item.is_start) begin
      // a start drops whatever transfer is running
      busy_nxt      = 1'b1;
      dir_nxt       = item.direction;
      row_bytes_nxt = item.row_bytes;
      skip_nxt      = item.skip_bytes;
      rows_nxt      = item.rows_left;
      off_nxt       = '0;
      lptr_nxt      = item.local_ptr;
      dptr_nxt      = item.dram_ptr;
    end else if (busy_r) begin
      tv_nxt    = 1'b1;
      dword_nxt = ({dptr_r[DWORD_W-1:2], 2'b00} + {{(DWORD_W-ROWB_W){1'b0}}, off_r})
                  & ~DWORD_W'(3);
      lword_nxt = ({lptr_r[LOCAL_W-1:2], 2'b00} + off_r) & ~LOCAL_W'(3);
      off_nxt   = off_inc;
      if (off_inc >= row_bytes_r) begin
        last_nxt = (rows_r == '0);
        dptr_nxt = dptr_r + {{(DRAM_W-ROWB_W){1'b0}}, row_bytes_r}
                          + {{(DRAM_W-SKIP_W){1'b0}}, skip_r};
        lptr_nxt = lptr_r + row_bytes_r;
        off_nxt  = '0;
        if (rows_r == '0) begin
          busy_nxt = 1'b0;
        end else begin
          rows_nxt = rows_r - ROWS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      dir_r       <= 1'b0;
      row_bytes_r <= '0;
      skip_r      <= '0;
      rows_r      <= '0;
      off_r       <= '0;
      lptr_r      <= '0;
      dptr_r      <= '0;
      ovalid_r    <= 1'b0;
    end else begin
      if (item_take) begin
        busy_r      <= busy_nxt;
        dir_r       <= dir_nxt;
        row_bytes_r <= row_bytes_nxt;
        skip_r      <= skip_nxt;
        rows_r      <= rows_nxt;
        off_r       <= off_nxt;
        lptr_r      <= lptr_nxt;
        dptr_r      <= dptr_nxt;
        ovalid_r    <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      tv_r    <= tv_nxt;
      dword_r <= dword_nxt;
      lword_r <= lword_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid              = ovalid_r;
  assign out_transfer_valid     = tv_r;
  assign out_direction_out      = dir_r;
  assign out_dram_word_address  = dword_r;
  assign out_local_word_address = lword_r;
  assign out_last_word          = last_r;
  assign out_local_pointer      = lptr_r;
  assign out_dram_pointer       = dptr_r;

endmodule

// ===== design/strided_dma_address_generator_unit.sv =====
`timescale 1ns / 1ps

// channel  | handshake          | payload
// in       | in_valid/in_stall  | operation, addresses, row shape, to_dram
// out      | out_valid/out_stall| transfer flag, direction, word addresses, last, pointers
//
// one word per cycle while out_stall is low and the queue holds an item; each item is
// written to the queue at acceptance; its result is registered in the back end output
// register when taken; back end pointers update once per word, which sets the rate
// rst_n is synchronous, active low, and clears the queue and sequencer state
// in_stall rises only when the queue is full; out_stall holds the output word
// and the back end, while the front keeps filling the queue

module strided_dma_address_generator_unit import sdag_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_operation,
  input  logic [LOCAL_W-1:0]  in_local_address,
  input  logic [DRAM_W-1:0]   in_dram_address,
  input  logic [LEN_W-1:0]    in_row_length_minus_one,
  input  logic [ROWS_W-1:0]   in_row_count_minus_one,
  input  logic [SKIP_W-1:0]   in_row_skip,
  input  logic                in_to_dram,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_transfer_valid,
  output logic                out_direction_out,
  output logic [DWORD_W-1:0]  out_dram_word_address,
  output logic [LOCAL_W-1:0]  out_local_word_address,
  output logic                out_last_word,
  output logic [LOCAL_W-1:0]  out_local_pointer,
  output logic [DRAM_W-1:0]   out_dram_pointer
);

  sdag_item_t front_item;
  sdag_item_t head_item;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;

  assign in_stall = q_full;

  sdag_front u_front (
    .in_operation            (in_operation),
    .in_local_address        (in_local_address),
    .in_dram_address         (in_dram_address),
    .in_row_length_minus_one (in_row_length_minus_one),
    .in_row_count_minus_one  (in_row_count_minus_one),
    .in_row_skip             (in_row_skip),
    .in_to_dram              (in_to_dram),
    .item                    (front_item)
  );

  sdag_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  sdag_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .item_valid             (q_not_empty),
    .item                   (head_item),
    .item_take              (q_pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_transfer_valid     (out_transfer_valid),
    .out_direction_out      (out_direction_out),
    .out_dram_word_address  (out_dram_word_address),
    .out_local_word_address (out_local_word_address),
    .out_last_word          (out_last_word),
    .out_local_pointer      (out_local_pointer),
    .out_dram_pointer       (out_dram_pointer)
  );

endmodule

// ===== verif/strided_dma_address_generator_unit_test.sv =====
`timescale 1ns / 1ps

module strided_dma_address_generator_unit_test;
  import sdag_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_ITEMS = 500;

  localparam logic [LOCAL_W-1:0] PAGE_OFFSET_MASK = 13'h0FFC;

  typedef struct packed {
    logic                operation;
    logic [LOCAL_W-1:0]  local_address;
    logic [DRAM_W-1:0]   dram_address;
    logic [LEN_W-1:0]    row_length_minus_one;
    logic [ROWS_W-1:0]   row_count_minus_one;
    logic [SKIP_W-1:0]   row_skip;
    logic                to_dram;
  } dma_cmd_t;

  typedef struct packed {
    logic                transfer_valid;
    logic                direction_out;
    logic [DWORD_W-1:0]  dram_word_address;
    logic [LOCAL_W-1:0]  local_word_address;
    logic                last_word;
    logic [LOCAL_W-1:0]  local_pointer;
    logic [DRAM_W-1:0]   dram_pointer;
  } xfer_word_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_operation = OP_START;
  logic [LOCAL_W-1:0]  in_local_address = '0;
  logic [DRAM_W-1:0]   in_dram_address = '0;
  logic [LEN_W-1:0]    in_row_length_minus_one = '0;
  logic [ROWS_W-1:0]   in_row_count_minus_one = '0;
  logic [SKIP_W-1:0]   in_row_skip = '0;
  logic                in_to_dram = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_transfer_valid;
  logic                out_direction_out;
  logic [DWORD_W-1:0]  out_dram_word_address;
  logic [LOCAL_W-1:0]  out_local_word_address;
  logic                out_last_word;
  logic [LOCAL_W-1:0]  out_local_pointer;
  logic [DRAM_W-1:0]   out_dram_pointer;

  dma_cmd_t   cmd_queue[$];
  xfer_word_t expected_words[$];
  dma_cmd_t   next_cmd;
  dma_cmd_t   accepted_cmd;
  xfer_word_t oldest_word;

  int  error_count = 0;
  int  cycle_count = 0;
  int  in_gap = 0;
  int  stall_left = 0;
  int  calm_cycles = 0;
  bit  in_taken = 1'b0;

  // sequencer state as the block keeps it
  logic                seq_busy = 1'b0;
  logic                seq_direction = 1'b0;
  logic [ROWB_W-1:0]   seq_row_bytes = '0;
  logic [SKIP_W-1:0]   seq_skip = '0;
  logic [ROWS_W-1:0]   seq_rows_left = '0;
  logic [ROWB_W-1:0]   seq_offset = '0;
  logic [LOCAL_W-1:0]  seq_local = '0;
  logic [DRAM_W-1:0]   seq_dram = '0;

  strided_dma_address_generator_unit DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_operation            (in_operation),
    .in_local_address        (in_local_address),
    .in_dram_address         (in_dram_address),
    .in_row_length_minus_one (in_row_length_minus_one),
    .in_row_count_minus_one  (in_row_count_minus_one),
    .in_row_skip             (in_row_skip),
    .in_to_dram              (in_to_dram),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_transfer_valid      (out_transfer_valid),
    .out_direction_out       (out_direction_out),
    .out_dram_word_address   (out_dram_word_address),
    .out_local_word_address  (out_local_word_address),
    .out_last_word           (out_last_word),
    .out_local_pointer       (out_local_pointer),
    .out_dram_pointer        (out_dram_pointer)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // row length rounded up to 8, clamped so the first row stays in its 4 KiB page
  function automatic logic [ROWB_W-1:0] first_row_bytes(input logic [LOCAL_W-1:0] local_addr,
                                                        input logic [LEN_W-1:0] len_m1);
    int len;
    int page_off;
    len = int'(len_m1) + 1;
    len = (len + 7) & ~7;
    page_off = int'(local_addr & PAGE_OFFSET_MASK);
    if (page_off + len > int'(PAGE_SIZE)) len = int'(PAGE_SIZE) - page_off;
    return ROWB_W'(len);
  endfunction

  function automatic xfer_word_t advance_sequencer(input dma_cmd_t c);
    xfer_word_t w;
    w = '0;
    if (c.operation == OP_START) begin
      seq_local     = {c.local_address[LOCAL_W-1:2], 2'b00};
      seq_dram      = {c.dram_address[DRAM_W-1:3], 3'b000};
      seq_row_bytes = first_row_bytes(c.local_address, c.row_length_minus_one);
      seq_rows_left = c.row_count_minus_one;
      seq_skip      = c.row_skip;
      seq_direction = c.to_dram;
      seq_offset    = '0;
      seq_busy      = 1'b1;
    end else if (seq_busy) begin
      w.transfer_valid     = 1'b1;
      w.dram_word_address  = {seq_dram[DWORD_W-1:2], 2'b00} + DWORD_W'(seq_offset);
      w.dram_word_address[1:0] = 2'b00;
      w.local_word_address = {seq_local[LOCAL_W-1:2], 2'b00} + LOCAL_W'(seq_offset);
      w.local_word_address[1:0] = 2'b00;
      seq_offset = seq_offset + WORD_BYTES;
      if (seq_offset >= seq_row_bytes) begin
        w.last_word = (seq_rows_left == '0);
        seq_dram    = seq_dram + DRAM_W'(seq_row_bytes) + DRAM_W'(seq_skip);
        seq_local   = seq_local + LOCAL_W'(seq_row_bytes);
        seq_offset  = '0;
        if (seq_rows_left == '0) seq_busy = 1'b0;
        else seq_rows_left = seq_rows_left - ROWS_W'(1);
      end
    end
    w.direction_out = seq_direction;
    w.local_pointer = seq_local;
    w.dram_pointer  = seq_dram;
    return w;
  endfunction

  task automatic add_start(input logic [LOCAL_W-1:0] la, input logic [DRAM_W-1:0] da,
                           input logic [LEN_W-1:0] lm, input logic [ROWS_W-1:0] rc,
                           input logic [SKIP_W-1:0] sk, input logic dir);
    cmd_queue.push_back('{OP_START, la, da, lm, rc, sk, dir});
  endtask

  // step words carry random payload that the block must ignore
  task automatic add_steps(input int n);
    for (int i = 0; i < n; i++) begin
      cmd_queue.push_back('{OP_STEP, LOCAL_W'($urandom()), DRAM_W'($urandom()),
                            LEN_W'($urandom()), ROWS_W'($urandom()), SKIP_W'($urandom()),
                            1'($urandom())});
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (calm_cycles > 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (calm_cycles > 0) calm_cycles--;
      else if ($urandom_range(0, 199) == 0) calm_cycles = $urandom_range(30, 80);

      if (!in_valid || in_taken) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (cmd_queue.size() != 0) begin
          next_cmd = cmd_queue.pop_front();
          in_operation            <= next_cmd.operation;
          in_local_address        <= next_cmd.local_address;
          in_dram_address         <= next_cmd.dram_address;
          in_row_length_minus_one <= next_cmd.row_length_minus_one;
          in_row_count_minus_one  <= next_cmd.row_count_minus_one;
          in_row_skip             <= next_cmd.row_skip;
          in_to_dram              <= next_cmd.to_dram;
          in_valid                <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end

      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_count++;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      accepted_cmd = '{in_operation, in_local_address, in_dram_address, in_row_length_minus_one,
                       in_row_count_minus_one, in_row_skip, in_to_dram};
      expected_words.push_back(advance_sequencer(accepted_cmd));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("word with no expectation pending: dram 0x%0h local 0x%0h",
               out_dram_word_address, out_local_word_address);
        error_count++;
      end else begin
        oldest_word = expected_words.pop_front();
        check_field("transfer_valid", 32'(oldest_word.transfer_valid), 32'(out_transfer_valid));
        check_field("direction_out", 32'(oldest_word.direction_out), 32'(out_direction_out));
        check_field("dram_word_address", 32'(oldest_word.dram_word_address),
                    32'(out_dram_word_address));
        check_field("local_word_address", 32'(oldest_word.local_word_address),
                    32'(out_local_word_address));
        check_field("last_word", 32'(oldest_word.last_word), 32'(out_last_word));
        check_field("local_pointer", 32'(oldest_word.local_pointer), 32'(out_local_pointer));
        check_field("dram_pointer", 32'(oldest_word.dram_pointer), 32'(out_dram_pointer));
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("strided_dma_address_generator_unit_test NOT OK");
    $finish;
  end

  initial begin
    int directed_count;
    int total_words;
    int steps;
    logic [LOCAL_W-1:0] la;
    logic [LEN_W-1:0]   lm;
    logic [ROWS_W-1:0]  rc;

    // step while idle, then a two word transfer plus one extra step
    add_steps(1);
    add_start('0, '0, '0, '0, '0, 1'b0);
    add_steps(3);
    // page end gives one word rows; both pointers wrap with the largest skip
    add_start('1, '1, '0, 8'd1, '1, 1'b1);
    add_steps(2);
    add_start(13'h0FFE, 24'h7FFFF9, 12'h010, 8'd3, 12'h001, 1'b0);
    add_steps(4);
    // largest row length from a page boundary
    add_start(13'h1000, 24'h800000, '1, '0, '0, 1'b1);
    add_steps(3);
    // row clamped at the page end, then cut short by a new start
    add_start(13'h0F00, 24'h000123, 12'h1FF, '0, 12'h0FF, 1'b0);
    add_steps(2);
    add_start(13'h0AB3, 24'hFFFFF8, '1, '1, '1, 1'b1);
    add_steps(2);
    directed_count = cmd_queue.size();

    while (cmd_queue.size() - directed_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        la = LOCAL_W'($urandom());
        lm = ($urandom_range(0, 99) < 80) ? LEN_W'($urandom_range(0, 31)) : LEN_W'($urandom());
        rc = ($urandom_range(0, 99) < 85) ? ROWS_W'($urandom_range(0, 3)) : ROWS_W'($urandom());
        add_start(la, DRAM_W'($urandom()), lm, rc, SKIP_W'($urandom()), 1'($urandom()));
        total_words = (int'(rc) + 1) * int'(first_row_bytes(la, lm)) / 4;
        // long transfers and some short ones are cut off by the next start
        if (total_words > 64 || $urandom_range(0, 9) == 0)
          steps = $urandom_range(1, (total_words < 40) ? total_words : 40);
        else
          steps = total_words + (($urandom_range(0, 9) < 3) ? $urandom_range(1, 3) : 0);
        add_steps(steps);
      end else begin
        add_steps($urandom_range(1, 4));
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || in_valid) @(negedge clk);
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("strided_dma_address_generator_unit_test OK");
    end else begin
      $display("strided_dma_address_generator_unit_test NOT OK");
    end
    $finish;
  end

endmodule
